// ===== hdl/npal_pkg.sv =====
package npal_pkg;

    localparam int DEPTH         = 256;
    localparam int ADDR_BITS     = 48;
    localparam int IDX_BITS      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS      = $clog2(DEPTH + 1);
    localparam int OUT_IDX_BITS  = 8;
    localparam int OUT_OFS_BITS  = 48;
    localparam int DIST_BITS     = 32;
    localparam int ACTION_BITS   = 2;
    localparam logic [DIST_BITS-1:0] MAX_DIST_RESET = DIST_BITS'(1000);

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    status;
        logic                    found;
        logic [OUT_IDX_BITS-1:0] entry_index;
        logic [OUT_OFS_BITS-1:0] offset;
    } t_result;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic issue;
        logic scan_end;
        logic load_out;
    } t_ctrl;

endpackage

// ===== hdl/nearest_preceding_address_lookup_top.sv =====
// Insert, clear and ignored actions: the result is registered in r_res, then loaded into r_out
// once the output is free. Lookup: each stored entry is read once, newest first, through the
// single memory read port, compared against the query, and the nearest preceding hit is
// registered in r_res and then r_out; a full table holds 256 entries. One item is worked on
// at a time; the next input beat is taken while a result still waits.
// Synchronous active-low reset empties the table and sets max_distance to 1000; the memory is kept.
module nearest_preceding_address_lookup_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [npal_pkg::ACTION_BITS-1:0]    i_action,
    input  logic [npal_pkg::ADDR_BITS-1:0]      i_address,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_status,
    output logic                                o_found,
    output logic [npal_pkg::OUT_IDX_BITS-1:0]   o_entry_index,
    output logic [npal_pkg::OUT_OFS_BITS-1:0]   o_offset,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [npal_pkg::DIST_BITS-1:0]      i_max_distance
);
    import npal_pkg::*;

    logic [ADDR_BITS-1:0] mem [DEPTH];

    t_state                 r_state, n_state;
    t_ctrl                  ctrl;
    logic [CNT_BITS-1:0]    r_count, n_count;
    logic [DIST_BITS-1:0]   r_max_dist;
    logic [ADDR_BITS-1:0]   r_query;
    logic [IDX_BITS-1:0]    r_rd_idx;
    logic                   r_issue;
    logic                   r_v1;
    logic [IDX_BITS-1:0]    r_idx1;
    logic [ADDR_BITS-1:0]   r_rd_data;
    logic                   r_v2;
    logic                   r_le2;
    logic [ADDR_BITS-1:0]   r_d2;
    logic [IDX_BITS-1:0]    r_idx2;
    logic                   r_have;
    logic [ADDR_BITS-1:0]   r_best;
    logic [IDX_BITS-1:0]    r_best_idx;
    t_result                r_res, n_res;
    t_result                r_out;
    logic                   r_out_valid;
    logic                   full;
    logic                   mem_wr_en;
    logic                   hit;

    assign full      = (r_count >= CNT_BITS'(DEPTH));
    assign mem_wr_en = ctrl.accept && (t_action'(i_action) == ACT_INSERT) && !full;
    assign hit       = r_have && (r_best < ADDR_BITS'(r_max_dist));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (t_action'(i_action) == ACT_LOOKUP && r_count != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (!r_issue && !r_v1 && !r_v2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (r_state)
            S_IDLE: begin
                ctrl.in_ready = 1'b1;
                ctrl.accept   = i_in_valid;
            end
            S_SCAN: begin
                ctrl.issue    = r_issue;
                ctrl.scan_end = !r_issue && !r_v1 && !r_v2;
            end
            S_DONE: begin
                ctrl.load_out = !r_out_valid || i_out_ready;
            end
            default: ctrl = '0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_res   = r_res;
        if (ctrl.accept) begin
            n_res = '0;
            case (t_action'(i_action))
                ACT_INSERT: begin
                    if (full) begin
                        n_res.status = 1'b1;
                    end else begin
                        n_res.entry_index = OUT_IDX_BITS'(r_count);
                        n_count           = r_count + CNT_BITS'(1);
                    end
                end
                ACT_CLEAR: n_count = '0;
                default:   n_count = r_count;
            endcase
        end else if (ctrl.scan_end) begin
            n_res = '0;
            if (hit) begin
                n_res.found       = 1'b1;
                n_res.entry_index = OUT_IDX_BITS'(r_best_idx);
                n_res.offset      = OUT_OFS_BITS'(r_best);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            mem[r_count[IDX_BITS-1:0]] <= i_address;
        end
        if (ctrl.issue) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_dist  <= MAX_DIST_RESET;
            r_issue     <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_max_dist <= i_max_distance;
            end
            if (ctrl.accept && t_action'(i_action) == ACT_LOOKUP && r_count != '0) begin
                r_issue <= 1'b1;
                r_have  <= 1'b0;
            end else if (ctrl.issue && r_rd_idx == '0) begin
                r_issue <= 1'b0;
            end
            r_v1 <= ctrl.issue;
            r_v2 <= r_v1;
            if (r_v2 && r_le2 && (!r_have || r_d2 < r_best)) begin
                r_have <= 1'b1;
            end
            if (ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_query  <= i_address;
            r_rd_idx <= IDX_BITS'(r_count - CNT_BITS'(1));
        end else if (ctrl.issue) begin
            r_rd_idx <= r_rd_idx - IDX_BITS'(1);
        end
        r_idx1 <= r_rd_idx;
        r_le2  <= (r_rd_data <= r_query);
        r_d2   <= r_query - r_rd_data;
        r_idx2 <= r_idx1;
        if (r_v2 && r_le2 && (!r_have || r_d2 < r_best)) begin
            r_best     <= r_d2;
            r_best_idx <= r_idx2;
        end
        r_res <= n_res;
        if (ctrl.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready    = ctrl.in_ready;
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found       = r_out.found;
    assign o_entry_index = r_out.entry_index;
    assign o_offset      = r_out.offset;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("Entry count exceeds table depth.");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr_en |-> (r_state == S_IDLE) && !r_issue && !r_v1 && !r_v2)
        else $error("Table written while a lookup is in progress.");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_offset < OUT_OFS_BITS'(r_max_dist)) && !o_status)
        else $error("Hit reported outside the configured distance.");

    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.scan_end |=> (r_state == S_DONE))
        else $error("Scan finished without producing a result.");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import npal_pkg::*;

    typedef struct {
        t_action          act;
        logic [47:0]      addr;
        bit               typed;
        t_result          want;
    } t_probe;

    logic                    i_clk;
    logic                    i_rst_n        = 1'b0;
    logic                    i_in_valid     = 1'b0;
    logic [ACTION_BITS-1:0]  i_action       = ACT_INSERT;
    logic [ADDR_BITS-1:0]    i_address      = '0;
    logic                    i_out_ready    = 1'b0;
    logic                    i_cfg_valid    = 1'b0;
    logic [DIST_BITS-1:0]    i_max_distance = '0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic                    o_status;
    logic                    o_found;
    logic [OUT_IDX_BITS-1:0] o_entry_index;
    logic [OUT_OFS_BITS-1:0] o_offset;
    logic                    o_cfg_ready;

    logic [ADDR_BITS-1:0]    table_addr [DEPTH];
    int                      table_count = 0;
    logic [DIST_BITS-1:0]    distance_limit = MAX_DIST_RESET;
    logic [ADDR_BITS-1:0]    cluster_base = 48'h0000_4000_0000;
    t_result                 awaited_results [$];
    int                      n_fail = 0;
    bit                      gaps_on = 1'b1;
    bit                      hold_req = 1'b0;
    int                      hold_left = 0;

    t_probe probe_rows [21] = '{
        '{ACT_LOOKUP, 48'h0,              1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_NONE,   48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_INSERT, 48'h1000,           1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_INSERT, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 1'b0, 8'd1, 48'd0}},
        '{ACT_INSERT, 48'h1000,           1'b1, '{1'b0, 1'b0, 8'd2, 48'd0}},
        '{ACT_LOOKUP, 48'h1000,           1'b1, '{1'b0, 1'b1, 8'd2, 48'd0}},
        '{ACT_LOOKUP, 48'h13E7,           1'b1, '{1'b0, 1'b1, 8'd2, 48'd999}},
        '{ACT_LOOKUP, 48'h13E8,           1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_LOOKUP, 48'h0FFF,           1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 1'b1, 8'd1, 48'd0}},
        '{ACT_INSERT, 48'h0,              1'b1, '{1'b0, 1'b0, 8'd3, 48'd0}},
        '{ACT_LOOKUP, 48'h5,              1'b1, '{1'b0, 1'b1, 8'd3, 48'd5}},
        '{ACT_INSERT, 48'h8000_0000_0001, 1'b0, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_LOOKUP, 48'h8000_0000_0100, 1'b0, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_LOOKUP, 48'hAAAA_AAAA_AAAA, 1'b0, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_LOOKUP, 48'h5555_5555_5555, 1'b0, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_NONE,   48'h0,              1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_CLEAR,  48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_LOOKUP, 48'h1000,           1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_INSERT, 48'h5555_5555_5555, 1'b1, '{1'b0, 1'b0, 8'd0, 48'd0}},
        '{ACT_LOOKUP, 48'h5555_5555_5555, 1'b1, '{1'b0, 1'b1, 8'd0, 48'd0}}
    };

    nearest_preceding_address_lookup_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_address      (i_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_entry_index  (o_entry_index),
        .o_offset       (o_offset),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_max_distance (i_max_distance)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_result predict_access(t_action act, logic [ADDR_BITS-1:0] addr);
        t_result              r;
        bit                   have;
        logic [ADDR_BITS-1:0] best_dist;
        logic [ADDR_BITS-1:0] d;
        int                   best_idx;
        r = '0;
        have = 1'b0;
        best_dist = '0;
        best_idx = 0;
        case (act)
            ACT_INSERT: begin
                if (table_count >= DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    table_addr[table_count] = addr;
                    r.entry_index = 8'(table_count);
                    table_count++;
                end
            end
            ACT_LOOKUP: begin
                for (int i = table_count - 1; i >= 0; i--) begin
                    d = addr - table_addr[i];
                    if (table_addr[i] <= addr && (!have || d < best_dist)) begin
                        have = 1'b1;
                        best_dist = d;
                        best_idx = i;
                    end
                end
                if (have && best_dist < ADDR_BITS'(distance_limit)) begin
                    r.found = 1'b1;
                    r.entry_index = 8'(best_idx);
                    r.offset = best_dist;
                end
            end
            ACT_CLEAR: begin
                table_count = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] pick_address();
        case ($urandom_range(0, 3))
            0: return ADDR_BITS'({$urandom(), $urandom()});
            1: return ADDR_BITS'($urandom_range(0, 4095));
            2: return {ADDR_BITS{1'b1}} - ADDR_BITS'($urandom_range(0, 4095));
            default: return cluster_base + ADDR_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [ADDR_BITS-1:0] pick_query();
        logic [ADDR_BITS-1:0] base;
        if (table_count == 0 || $urandom_range(0, 9) < 3) begin
            return pick_address();
        end
        base = table_addr[$urandom_range(0, table_count - 1)];
        case ($urandom_range(0, 3))
            0: return base + ADDR_BITS'($urandom_range(0, 15));
            1: return base + ADDR_BITS'($urandom_range(0, 2000));
            2: return base + ADDR_BITS'(distance_limit) - 1'b1;
            default: return base + ADDR_BITS'(distance_limit);
        endcase
    endfunction

    task automatic send_beat(t_action act, logic [ADDR_BITS-1:0] addr,
                             bit typed = 1'b0, t_result want = '0);
        t_result predicted;
        if (gaps_on && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_address  <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_access(act, addr);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [DIST_BITS-1:0] value);
        i_in_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_max_distance <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        distance_limit = value;
    endtask

    task automatic random_traffic(int n_beats, int hold_at);
        int      r;
        t_action act;
        for (int k = 0; k < n_beats; k++) begin
            if (k == hold_at) hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3) act = ACT_CLEAR;
            else if (r < 5) act = ACT_NONE;
            else if (r < 45 && table_count < 48) act = ACT_INSERT;
            else act = ACT_LOOKUP;
            case (act)
                ACT_INSERT: send_beat(act, pick_address());
                ACT_LOOKUP: send_beat(act, pick_query());
                default:    send_beat(act, ADDR_BITS'({$urandom(), $urandom()}));
            endcase
        end
    endtask

    always @(posedge i_clk) begin : drain_results
        t_result want;
        if (o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result beat arrived with no beat outstanding");
                n_fail++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_status);
                    n_fail++;
                end
                if (o_found !== want.found) begin
                    $error("found expected %0d got %0d", want.found, o_found);
                    n_fail++;
                end
                if (o_entry_index !== want.entry_index) begin
                    $error("entry_index expected %0d got %0d", want.entry_index,
                           o_entry_index);
                    n_fail++;
                end
                if (o_offset !== want.offset) begin
                    $error("offset expected %h got %h", want.offset, o_offset);
                    n_fail++;
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(gaps_on && $urandom_range(0, 99) < 7);
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_rows[i]) begin
            send_beat(probe_rows[i].act, probe_rows[i].addr, probe_rows[i].typed,
                      probe_rows[i].want);
        end

        // A long stretch with both sides always willing.
        gaps_on = 1'b0;
        write_limit({DIST_BITS{1'b1}});
        random_traffic(120, -1);
        gaps_on = 1'b1;

        write_limit('0);
        random_traffic(40, -1);

        // The receiver holds off part-way through, so the block backs up.
        cluster_base = ADDR_BITS'({$urandom(), $urandom()});
        write_limit(DIST_BITS'($urandom_range(1, 3000)));
        random_traffic(150, 75);

        // Fill the table to the brim, then probe it while full.
        write_limit({DIST_BITS{1'b1}});
        send_beat(ACT_CLEAR, '0, 1'b1, '0);
        for (int i = 0; i < DEPTH; i++) send_beat(ACT_INSERT, pick_address());
        send_beat(ACT_INSERT, 48'h1234, 1'b1, '{1'b1, 1'b0, 8'd0, 48'd0});
        send_beat(ACT_INSERT, {ADDR_BITS{1'b1}}, 1'b1, '{1'b1, 1'b0, 8'd0, 48'd0});
        send_beat(ACT_NONE, {ADDR_BITS{1'b1}}, 1'b1, '0);
        for (int i = 0; i < 12; i++) send_beat(ACT_LOOKUP, pick_query());
        send_beat(ACT_CLEAR, '0, 1'b1, '0);
        send_beat(ACT_LOOKUP, {ADDR_BITS{1'b1}}, 1'b1, '0);

        write_limit($urandom());
        random_traffic(60, -1);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/npal_pkg.sv
hdl/nearest_preceding_address_lookup_top.sv
verif/tb.sv
